// ===== hw/rtl/cpvc_pkg.sv =====
// Package for the cascaded PI voltage/current loop unit.
// Holds widths, register codes, reset values, controller states and the
// command/configuration structs shared by all modules. No dependencies.
package cpvc_pkg;

	// Field and state widths
	localparam int unsigned MEAS_W  = 16;   // Q8.8 measurements and targets
	localparam int unsigned ERR_W   = 17;   // exact difference of two Q8.8 values
	localparam int unsigned GAIN_W  = 32;   // Q11.20 gains
	localparam int unsigned PROD_W  = GAIN_W + ERR_W;
	localparam int unsigned SUM_W   = PROD_W + 2;
	localparam int unsigned VACC_W  = 36;   // saturated outer accumulator
	localparam int unsigned TGT_SH  = 20;   // outer accumulator to Q8.8
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned DUTY_SH = 12;   // inner accumulator to Q0.16
	localparam int unsigned CACC_W  = DUTY_W + DUTY_SH;
	localparam int unsigned CMP_W   = 9;
	localparam int unsigned PER_W   = 16;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	localparam int unsigned PWM_PERIOD_DEF = 260;

	// Register reset values
	localparam logic [MEAS_W-1:0] CURRENT_LIMIT_RST = 16'h7FFF;
	localparam logic [GAIN_W-1:0] VOLT_GAIN_NEW_RST = 32'd524288;
	localparam logic [GAIN_W-1:0] VOLT_GAIN_OLD_RST = -32'sd524288;
	localparam logic [GAIN_W-1:0] CURR_GAIN_NEW_RST = 32'd1049;
	localparam logic [GAIN_W-1:0] CURR_GAIN_OLD_RST = -32'sd1049;
	localparam logic [DUTY_W-1:0] DUTY_LOW_RST      = 16'h0000;
	localparam logic [DUTY_W-1:0] DUTY_HIGH_RST     = 16'hFFFF;
	localparam logic [DUTY_W-1:0] DUTY_FLOOR_RST    = 16'h0000;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_CURRENT_LIMIT = 3'd0,
		REG_VOLT_GAIN_NEW = 3'd1,
		REG_VOLT_GAIN_OLD = 3'd2,
		REG_CURR_GAIN_NEW = 3'd3,
		REG_CURR_GAIN_OLD = 3'd4,
		REG_DUTY_LOW      = 3'd5,
		REG_DUTY_HIGH     = 3'd6,
		REG_DUTY_FLOOR    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [MEAS_W-1:0] current_limit;
		logic signed [GAIN_W-1:0] volt_gain_new;
		logic signed [GAIN_W-1:0] volt_gain_old;
		logic signed [GAIN_W-1:0] curr_gain_new;
		logic signed [GAIN_W-1:0] curr_gain_old;
		logic [DUTY_W-1:0]        duty_low;
		logic [DUTY_W-1:0]        duty_high;
		logic [DUTY_W-1:0]        duty_floor;
	} cfg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_V_MUL,
		ST_V_ACC,
		ST_C_MUL,
		ST_C_ACC,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic v_mul;
		logic v_acc;
		logic c_mul;
		logic c_acc;
		logic load_out;
	} cmd_t;

endpackage

// ===== hw/rtl/cpvc_if.sv =====
// Handshake interfaces for the sample request channel and result channel.
// Depends on cpvc_pkg for field widths.
interface cpvc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [cpvc_pkg::MEAS_W-1:0]  voltage_target;
	logic signed [cpvc_pkg::MEAS_W-1:0]  output_voltage;
	logic signed [cpvc_pkg::MEAS_W-1:0]  output_current;

	modport source (output valid, voltage_target, output_voltage, output_current,
		input ready);
	modport sink (input valid, voltage_target, output_voltage, output_current,
		output ready);
endinterface

interface cpvc_out_if;
	logic                                valid;
	logic                                ready;
	logic [cpvc_pkg::DUTY_W-1:0]         duty;
	logic [cpvc_pkg::CMP_W-1:0]          compare_value;
	logic signed [cpvc_pkg::MEAS_W-1:0]  current_target;

	modport source (output valid, duty, compare_value, current_target, input ready);
	modport sink (input valid, duty, compare_value, current_target, output ready);
endinterface

// ===== hw/rtl/cpvc_regs.sv =====
// APB configuration register file for the cascaded PI loop unit.
// Depends on cpvc_pkg for the register map, reset values and cfg_t.
module cpvc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cpvc_pkg::ADDR_W-1:0]    paddr,
	input  logic [cpvc_pkg::DATA_W-1:0]    pwdata,
	output logic [cpvc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output cpvc_pkg::cfg_t                 cfg
);
	cpvc_pkg::cfg_t     cfg_q;
	cpvc_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = cpvc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_limit <= cpvc_pkg::CURRENT_LIMIT_RST;
			cfg_q.volt_gain_new <= cpvc_pkg::VOLT_GAIN_NEW_RST;
			cfg_q.volt_gain_old <= cpvc_pkg::VOLT_GAIN_OLD_RST;
			cfg_q.curr_gain_new <= cpvc_pkg::CURR_GAIN_NEW_RST;
			cfg_q.curr_gain_old <= cpvc_pkg::CURR_GAIN_OLD_RST;
			cfg_q.duty_low      <= cpvc_pkg::DUTY_LOW_RST;
			cfg_q.duty_high     <= cpvc_pkg::DUTY_HIGH_RST;
			cfg_q.duty_floor    <= cpvc_pkg::DUTY_FLOOR_RST;
		end else if (wr_en) begin
			case (idx)
				cpvc_pkg::REG_CURRENT_LIMIT: cfg_q.current_limit <= pwdata[15:0];
				cpvc_pkg::REG_VOLT_GAIN_NEW: cfg_q.volt_gain_new <= pwdata;
				cpvc_pkg::REG_VOLT_GAIN_OLD: cfg_q.volt_gain_old <= pwdata;
				cpvc_pkg::REG_CURR_GAIN_NEW: cfg_q.curr_gain_new <= pwdata;
				cpvc_pkg::REG_CURR_GAIN_OLD: cfg_q.curr_gain_old <= pwdata;
				cpvc_pkg::REG_DUTY_LOW:      cfg_q.duty_low      <= pwdata[15:0];
				cpvc_pkg::REG_DUTY_HIGH:     cfg_q.duty_high     <= pwdata[15:0];
				cpvc_pkg::REG_DUTY_FLOOR:    cfg_q.duty_floor    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			cpvc_pkg::REG_CURRENT_LIMIT: prdata = {16'd0, cfg_q.current_limit};
			cpvc_pkg::REG_VOLT_GAIN_NEW: prdata = cfg_q.volt_gain_new;
			cpvc_pkg::REG_VOLT_GAIN_OLD: prdata = cfg_q.volt_gain_old;
			cpvc_pkg::REG_CURR_GAIN_NEW: prdata = cfg_q.curr_gain_new;
			cpvc_pkg::REG_CURR_GAIN_OLD: prdata = cfg_q.curr_gain_old;
			cpvc_pkg::REG_DUTY_LOW:      prdata = {16'd0, cfg_q.duty_low};
			cpvc_pkg::REG_DUTY_HIGH:     prdata = {16'd0, cfg_q.duty_high};
			cpvc_pkg::REG_DUTY_FLOOR:    prdata = {16'd0, cfg_q.duty_floor};
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/cpvc_ctrl.sv =====
// Sequencing state machine for the cascaded PI loop unit.
// Depends on cpvc_pkg for state_t and cmd_t; drives the datapath commands.
module cpvc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output cpvc_pkg::cmd_t  cmd
);
	cpvc_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cpvc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = cpvc_pkg::ST_V_MUL;
				end
			end
			cpvc_pkg::ST_V_MUL: begin
				cmd.v_mul = 1'b1;
				state_d   = cpvc_pkg::ST_V_ACC;
			end
			cpvc_pkg::ST_V_ACC: begin
				cmd.v_acc = 1'b1;
				state_d   = cpvc_pkg::ST_C_MUL;
			end
			cpvc_pkg::ST_C_MUL: begin
				cmd.c_mul = 1'b1;
				state_d   = cpvc_pkg::ST_C_ACC;
			end
			cpvc_pkg::ST_C_ACC: begin
				cmd.c_acc = 1'b1;
				state_d   = cpvc_pkg::ST_OUT;
			end
			cpvc_pkg::ST_OUT: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = cpvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cpvc_pkg::ST_IDLE;
			end
		endcase
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Only one datapath step per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.v_mul, cmd.v_acc, cmd.c_mul, cmd.c_acc, cmd.load_out}))
		else $error("more than one datapath command active");

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// An accepted request starts the outer multiply next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.v_mul)
		else $error("accepted request did not start");

	// Inner loop runs only after the outer accumulate
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.c_mul |-> $past(cmd.v_acc))
		else $error("inner multiply out of order");

endmodule

// ===== hw/rtl/cpvc_dp.sv =====
// Datapath of the cascaded PI loop unit: loop state, products, accumulators,
// clamps and the result register. Depends on cpvc_pkg; steered by cpvc_ctrl.
module cpvc_dp #(
	parameter int unsigned PWM_PERIOD = cpvc_pkg::PWM_PERIOD_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpvc_pkg::cmd_t                      cmd,
	input  cpvc_pkg::cfg_t                      cfg,
	input  logic signed [cpvc_pkg::MEAS_W-1:0]  voltage_target,
	input  logic signed [cpvc_pkg::MEAS_W-1:0]  output_voltage,
	input  logic signed [cpvc_pkg::MEAS_W-1:0]  output_current,
	output logic [cpvc_pkg::DUTY_W-1:0]         duty,
	output logic [cpvc_pkg::CMP_W-1:0]          compare_value,
	output logic signed [cpvc_pkg::MEAS_W-1:0]  current_target
);
	localparam int unsigned ERR_W  = cpvc_pkg::ERR_W;
	localparam int unsigned PROD_W = cpvc_pkg::PROD_W;
	localparam int unsigned SUM_W  = cpvc_pkg::SUM_W;
	localparam int unsigned VACC_W = cpvc_pkg::VACC_W;
	localparam int unsigned CACC_W = cpvc_pkg::CACC_W;
	localparam int unsigned MEAS_W = cpvc_pkg::MEAS_W;
	localparam int unsigned DUTY_W = cpvc_pkg::DUTY_W;
	localparam int unsigned PER_W  = cpvc_pkg::PER_W;
	localparam int unsigned CMP_W  = cpvc_pkg::CMP_W;
	localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'sd1 <<< (VACC_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] VMIN = SUM_W'(-(64'sd1 <<< (VACC_W - 1)));
	localparam logic [PER_W-1:0] PERIOD = PER_W'(PWM_PERIOD);

	// Loop state
	logic signed [VACC_W-1:0] volt_accum_q;
	logic signed [ERR_W-1:0]  volt_err_prev_q;
	logic [CACC_W-1:0]        curr_accum_q;
	logic signed [ERR_W-1:0]  curr_err_prev_q;

	// Working registers
	logic signed [ERR_W-1:0]  volt_err_q;
	logic signed [MEAS_W-1:0] meas_curr_q;
	logic signed [PROD_W-1:0] prod_new_q, prod_old_q;
	logic signed [MEAS_W-1:0] tgt_q;
	logic [DUTY_W-1:0]        duty_q;

	// Result register
	logic [DUTY_W-1:0]        duty_out_q;
	logic [CMP_W-1:0]         cmp_out_q;
	logic signed [MEAS_W-1:0] tgt_out_q;

	logic signed [ERR_W-1:0]  volt_err;
	logic signed [ERR_W-1:0]  curr_err;
	logic signed [SUM_W-1:0]  vsum, csum;
	logic signed [VACC_W-1:0] vsat;
	logic signed [MEAS_W-1:0] tgt_raw, tgt_cap;
	logic signed [SUM_W-1:0]  clamp_lo, clamp_hi;
	logic [CACC_W-1:0]        cclamp;
	logic [DUTY_W-1:0]        duty_raw, duty_fl;
	logic [2*PER_W-1:0]       cmp_prod;

	assign volt_err = ERR_W'(voltage_target) - ERR_W'(output_voltage);
	assign curr_err = ERR_W'(tgt_q) - ERR_W'(meas_curr_q);

	// Outer accumulate, saturate and cap
	always_comb begin
		vsum = SUM_W'(volt_accum_q) + SUM_W'(prod_new_q) + SUM_W'(prod_old_q);
		if (vsum > VMAX) begin
			vsat = VMAX[VACC_W-1:0];
		end else if (vsum < VMIN) begin
			vsat = VMIN[VACC_W-1:0];
		end else begin
			vsat = vsum[VACC_W-1:0];
		end
		tgt_raw = vsat[VACC_W-1:cpvc_pkg::TGT_SH];
		tgt_cap = (tgt_raw > cfg.current_limit) ? cfg.current_limit : tgt_raw;
	end

	// Inner accumulate, anti-windup clamp (low test first) and floor
	always_comb begin
		csum     = SUM_W'($signed({1'b0, curr_accum_q})) + SUM_W'(prod_new_q)
			+ SUM_W'(prod_old_q);
		clamp_lo = SUM_W'($signed({1'b0, cfg.duty_low, {cpvc_pkg::DUTY_SH{1'b0}}}));
		clamp_hi = SUM_W'($signed({1'b0, cfg.duty_high, {cpvc_pkg::DUTY_SH{1'b0}}}));
		if (csum < clamp_lo) begin
			cclamp = clamp_lo[CACC_W-1:0];
		end else if (csum > clamp_hi) begin
			cclamp = clamp_hi[CACC_W-1:0];
		end else begin
			cclamp = csum[CACC_W-1:0];
		end
		duty_raw = cclamp[CACC_W-1:cpvc_pkg::DUTY_SH];
		duty_fl  = (duty_raw < cfg.duty_floor) ? cfg.duty_floor : duty_raw;
	end

	// Timer compare: period times duty, keep the integer part
	assign cmp_prod = PERIOD * duty_q;

	// Loop state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_accum_q    <= '0;
			volt_err_prev_q <= '0;
			curr_accum_q    <= '0;
			curr_err_prev_q <= '0;
		end else begin
			if (cmd.v_acc) begin
				volt_accum_q    <= vsat;
				volt_err_prev_q <= volt_err_q;
			end
			if (cmd.c_mul) begin
				curr_err_prev_q <= curr_err;
			end
			if (cmd.c_acc) begin
				curr_accum_q <= cclamp;
			end
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			volt_err_q  <= volt_err;
			meas_curr_q <= output_current;
		end
		if (cmd.v_mul) begin
			prod_new_q <= PROD_W'($signed(cfg.volt_gain_new)) * PROD_W'(volt_err_q);
			prod_old_q <= PROD_W'($signed(cfg.volt_gain_old)) * PROD_W'(volt_err_prev_q);
		end
		if (cmd.v_acc) begin
			tgt_q <= tgt_cap;
		end
		if (cmd.c_mul) begin
			prod_new_q <= PROD_W'($signed(cfg.curr_gain_new)) * PROD_W'(curr_err);
			prod_old_q <= PROD_W'($signed(cfg.curr_gain_old)) * PROD_W'(curr_err_prev_q);
		end
		if (cmd.c_acc) begin
			duty_q <= duty_fl;
		end
		if (cmd.load_out) begin
			duty_out_q <= duty_q;
			cmp_out_q  <= cmp_prod[PER_W +: CMP_W];
			tgt_out_q  <= tgt_q;
		end
	end

	assign duty           = duty_out_q;
	assign compare_value  = cmp_out_q;
	assign current_target = tgt_out_q;

endmodule

// ===== hw/rtl/cascaded_pi_voltage_current_loop_unit.sv =====
// Top level of the cascaded PI voltage/current loop unit.
// Depends on cpvc_pkg, cpvc_if, cpvc_regs, cpvc_ctrl and cpvc_dp.
//
// Usage: each request on sample_in carries a voltage target and the
// measured output voltage and current (signed Q8.8). An outer velocity-form
// PI loop makes a current target, capped at current_limit; an inner loop
// makes the duty, clamped for anti-windup and floored. Each request gives
// exactly one result on result_out: duty (Q0.16), timer compare value and
// the capped current target.
// Timing: a request is taken in the idle state, then the controller steps
// through the outer multiply, outer accumulate, inner multiply, inner
// accumulate and result load states in that order. The unit takes no new
// request until the previous one has passed the load step; a single
// controller sequence runs through the shared product registers.
// Stall: a finished result waits in the output register; the next request
// is still accepted and computed, and holds in the load step until the
// output register is taken.
// Reset: arst_n resets the loop state, the controller and the config registers,
// not the datapath working/result registers. Configure over APB only while idle.
module cascaded_pi_voltage_current_loop_unit #(
	parameter int unsigned PWM_PERIOD = cpvc_pkg::PWM_PERIOD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cpvc_in_if.sink                       sample_in,
	cpvc_out_if.source                    result_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpvc_pkg::ADDR_W-1:0]   paddr,
	input  logic [cpvc_pkg::DATA_W-1:0]   pwdata,
	output logic [cpvc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	cpvc_pkg::cfg_t cfg;
	cpvc_pkg::cmd_t cmd;

	// Configuration registers
	cpvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	cpvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd)
	);

	// Arithmetic
	cpvc_dp #(
		.PWM_PERIOD (PWM_PERIOD)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.voltage_target (sample_in.voltage_target),
		.output_voltage (sample_in.output_voltage),
		.output_current (sample_in.output_current),
		.duty           (result_out.duty),
		.compare_value  (result_out.compare_value),
		.current_target (result_out.current_target)
	);

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the cascaded PI voltage/current loop unit: drives sample requests,
// programs the loop over APB and checks every result against a cycle-free predictor.
// Depends on cpvc_pkg, cpvc_if and the RTL of cascaded_pi_voltage_current_loop_unit.
module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE_TICKS = 8;
	localparam longint VSUM_MAX = (longint'(1) <<< (cpvc_pkg::VACC_W - 1)) - 1;
	localparam longint VSUM_MIN = -(longint'(1) <<< (cpvc_pkg::VACC_W - 1));

	typedef struct {
		logic signed [cpvc_pkg::MEAS_W-1:0] volt_target;
		logic signed [cpvc_pkg::MEAS_W-1:0] volt_meas;
		logic signed [cpvc_pkg::MEAS_W-1:0] curr_meas;
		bit                                 drain;
	} sample_t;

	typedef struct {
		logic [cpvc_pkg::DUTY_W-1:0]        duty;
		logic [cpvc_pkg::CMP_W-1:0]         compare_value;
		logic signed [cpvc_pkg::MEAS_W-1:0] current_target;
	} loop_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [cpvc_pkg::ADDR_W-1:0]  paddr;
	logic [cpvc_pkg::DATA_W-1:0]  pwdata;
	logic [cpvc_pkg::DATA_W-1:0]  prdata;
	logic                         pready;

	cpvc_in_if  sample_in ();
	cpvc_out_if result_out ();

	cascaded_pi_voltage_current_loop_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.result_out (result_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Predictor state: live configuration and both loop integrators
	cpvc_pkg::cfg_t loop_cfg;
	longint       volt_sum       = 0;
	longint       volt_err_last  = 0;
	longint       curr_sum       = 0;
	longint       curr_err_last  = 0;

	sample_t      sample_queue[$];
	loop_result_t expected_results[$];

	int unsigned  cycle_count    = 0;
	int unsigned  mismatch_count = 0;
	bit           in_fired       = 0;
	bit           out_fired      = 0;
	int           send_gap       = 0;
	int           recv_gap       = 0;
	bit           send_calm      = 0;
	bit           recv_calm      = 0;
	int           op_volt        = 0;
	int           op_curr        = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic cpvc_pkg::cfg_t make_cfg(logic [15:0] limit, logic [31:0] vgn,
			logic [31:0] vgo, logic [31:0] cgn, logic [31:0] cgo, logic [15:0] lo,
			logic [15:0] hi, logic [15:0] flr);
		cpvc_pkg::cfg_t c;
		c.current_limit = limit;
		c.volt_gain_new = vgn;
		c.volt_gain_old = vgo;
		c.curr_gain_new = cgn;
		c.curr_gain_old = cgo;
		c.duty_low      = lo;
		c.duty_high     = hi;
		c.duty_floor    = flr;
		return c;
	endfunction

	// Compute one control update and queue the result it must produce
	function automatic void predict_loop(logic signed [cpvc_pkg::MEAS_W-1:0] vt,
			logic signed [cpvc_pkg::MEAS_W-1:0] vo, logic signed [cpvc_pkg::MEAS_W-1:0] io);
		longint       err;
		longint       tgt;
		longint       lo;
		longint       hi;
		longint       duty_calc;
		longint       cmp_calc;
		loop_result_t r;
		// outer voltage loop, saturated to the accumulator range
		err = longint'(vt) - longint'(vo);
		volt_sum = volt_sum + longint'($signed(loop_cfg.volt_gain_new)) * err
			+ longint'($signed(loop_cfg.volt_gain_old)) * volt_err_last;
		if (volt_sum > VSUM_MAX) begin
			volt_sum = VSUM_MAX;
		end else if (volt_sum < VSUM_MIN) begin
			volt_sum = VSUM_MIN;
		end
		volt_err_last = err;
		tgt = volt_sum >>> cpvc_pkg::TGT_SH;
		if (tgt > longint'($signed(loop_cfg.current_limit)))
			tgt = longint'($signed(loop_cfg.current_limit));
		// inner current loop with anti-windup; low bound is tested first
		err = tgt - longint'(io);
		curr_sum = curr_sum + longint'($signed(loop_cfg.curr_gain_new)) * err
			+ longint'($signed(loop_cfg.curr_gain_old)) * curr_err_last;
		curr_err_last = err;
		lo = longint'({48'd0, loop_cfg.duty_low}) <<< cpvc_pkg::DUTY_SH;
		hi = longint'({48'd0, loop_cfg.duty_high}) <<< cpvc_pkg::DUTY_SH;
		if (curr_sum < lo) begin
			curr_sum = lo;
		end else if (curr_sum > hi) begin
			curr_sum = hi;
		end
		duty_calc = curr_sum >>> cpvc_pkg::DUTY_SH;
		if (duty_calc < longint'({48'd0, loop_cfg.duty_floor}))
			duty_calc = longint'({48'd0, loop_cfg.duty_floor});
		cmp_calc = (longint'(cpvc_pkg::PWM_PERIOD_DEF) * duty_calc) >>> 16;
		r.duty           = duty_calc[cpvc_pkg::DUTY_W-1:0];
		r.compare_value  = cmp_calc[cpvc_pkg::CMP_W-1:0];
		r.current_target = tgt[cpvc_pkg::MEAS_W-1:0];
		expected_results.push_back(r);
	endfunction

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic logic signed [cpvc_pkg::MEAS_W-1:0] sat16(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[cpvc_pkg::MEAS_W-1:0];
	endfunction

	function automatic void add_sample(int vt, int vo, int io);
		sample_t s;
		s.volt_target = vt[cpvc_pkg::MEAS_W-1:0];
		s.volt_meas   = vo[cpvc_pkg::MEAS_W-1:0];
		s.curr_meas   = io[cpvc_pkg::MEAS_W-1:0];
		s.drain       = 0;
		sample_queue.push_back(s);
	endfunction

	// Mostly settled operating points with noise, some steps, some raw noise
	function automatic void add_random(int count);
		int      mode;
		sample_t s;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(0, 99);
			if (mode < 8) begin
				op_volt = int'($urandom_range(0, 65535)) - 32768;
				op_curr = int'($urandom_range(0, 65535)) - 32768;
			end
			if (mode < 70) begin
				s.volt_target = sat16(op_volt);
				s.volt_meas   = sat16(op_volt + int'($urandom_range(0, 600)) - 300);
				s.curr_meas   = sat16(op_curr + int'($urandom_range(0, 600)) - 300);
			end else begin
				s.volt_target = 16'($urandom);
				s.volt_meas   = 16'($urandom);
				s.curr_meas   = 16'($urandom);
			end
			s.drain = ($urandom_range(0, 149) == 0);
			sample_queue.push_back(s);
		end
	endfunction

	function automatic logic [31:0] rand_gain(int span);
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic cpvc_pkg::cfg_t random_cfg();
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] limit;
		logic [15:0] flr;
		a     = 16'($urandom);
		b     = 16'($urandom);
		limit = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
		flr   = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0;
		// keep the clamps ordered most of the time
		if ($urandom_range(0, 3) != 0 && a > b)
			{a, b} = {b, a};
		return make_cfg(limit, rand_gain(1 << 21), rand_gain(1 << 21), rand_gain(1 << 13),
			rand_gain(1 << 13), a, b, flr);
	endfunction

	task automatic apb_write(cpvc_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_config(cpvc_pkg::cfg_t c);
		apb_write(cpvc_pkg::REG_CURRENT_LIMIT, 32'(c.current_limit));
		apb_write(cpvc_pkg::REG_VOLT_GAIN_NEW, c.volt_gain_new);
		apb_write(cpvc_pkg::REG_VOLT_GAIN_OLD, c.volt_gain_old);
		apb_write(cpvc_pkg::REG_CURR_GAIN_NEW, c.curr_gain_new);
		apb_write(cpvc_pkg::REG_CURR_GAIN_OLD, c.curr_gain_old);
		apb_write(cpvc_pkg::REG_DUTY_LOW, 32'(c.duty_low));
		apb_write(cpvc_pkg::REG_DUTY_HIGH, 32'(c.duty_high));
		apb_write(cpvc_pkg::REG_DUTY_FLOOR, 32'(c.duty_floor));
		loop_cfg = c;
	endtask

	// Hold until every request is taken and every result is back, then settle
	task automatic wait_idle();
		do @(posedge clk);
		while (sample_queue.size() != 0 || sample_in.valid || expected_results.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Request driver: advance on acceptance, idle for a drawn gap between requests
	always @(negedge clk) begin
		sample_t s;
		if (arst_n) begin
			if (in_fired)
				send_gap = draw_gap(send_calm);
			if (!sample_in.valid || in_fired) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_in.valid <= 1'b0;
				end else if (sample_queue.size() != 0
						&& !(sample_queue[0].drain && expected_results.size() != 0)) begin
					s = sample_queue.pop_front();
					sample_in.voltage_target <= s.volt_target;
					sample_in.output_voltage <= s.volt_meas;
					sample_in.output_current <= s.curr_meas;
					sample_in.valid          <= 1'b1;
				end else begin
					sample_in.valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: stall for a drawn number of cycles after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fired)
				recv_gap = draw_gap(recv_calm);
			if (recv_gap > 0) begin
				recv_gap--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		loop_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			in_fired  <= arst_n && sample_in.valid && sample_in.ready;
			out_fired <= arst_n && result_out.valid && result_out.ready;
			if (arst_n && sample_in.valid && sample_in.ready)
				predict_loop(sample_in.voltage_target, sample_in.output_voltage,
					sample_in.output_current);
			if (arst_n && result_out.valid && result_out.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: duty=%0d cmp=%0d target=%0d",
							result_out.duty, result_out.compare_value,
							result_out.current_target);
				end else begin
					want = expected_results.pop_front();
					if (result_out.duty !== want.duty
							|| result_out.compare_value !== want.compare_value
							|| result_out.current_target !== want.current_target) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch at cycle %0d: duty %0d/%0d cmp %0d/%0d target %0d/%0d (exp/act)",
								cycle_count, want.duty, result_out.duty,
								want.compare_value, result_out.compare_value,
								want.current_target, result_out.current_target);
					end
				end
			end
		end
	end

	initial begin
		loop_cfg = make_cfg(cpvc_pkg::CURRENT_LIMIT_RST, cpvc_pkg::VOLT_GAIN_NEW_RST,
			cpvc_pkg::VOLT_GAIN_OLD_RST, cpvc_pkg::CURR_GAIN_NEW_RST,
			cpvc_pkg::CURR_GAIN_OLD_RST, cpvc_pkg::DUTY_LOW_RST, cpvc_pkg::DUTY_HIGH_RST,
			cpvc_pkg::DUTY_FLOOR_RST);
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		sample_in.valid          = 1'b0;
		sample_in.voltage_target = '0;
		sample_in.output_voltage = '0;
		sample_in.output_current = '0;
		result_out.ready         = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Power-up settings: field extremes and alternating bit patterns
		add_sample(0, 0, 0);
		add_sample(32767, -32768, -32768);
		add_sample(32767, -32768, 32767);
		add_sample(-32768, 32767, 32767);
		add_sample(-32768, 32767, -32768);
		add_sample(32767, 32767, 0);
		add_sample(-32768, -32768, 0);
		add_sample(256, 0, 0);
		add_sample(0, 256, -256);
		add_sample(1, 0, -1);
		add_sample(21845, -21846, 21845);
		add_sample(-21846, 21845, -21846);
		add_random(200);
		wait_idle();

		// Extreme gains: saturate the outer accumulator both ways, cap at the
		// lowest limit and floor every duty at full scale
		write_config(make_cfg(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 16'h0000, 16'hFFFF, 16'hFFFF));
		add_sample(32767, -32768, -32768);
		add_sample(32767, -32768, 32767);
		add_sample(-32768, 32767, 0);
		add_sample(-32768, 32767, 32767);
		add_sample(0, 0, 0);
		add_random(100);
		wait_idle();

		// Crossed clamps: accumulator must land on one of the two bounds
		write_config(make_cfg(16'd1024, 32'd524288, -32'sd524288, 32'd4096, -32'sd2048,
			16'd50000, 16'd1000, 16'd0));
		add_sample(2560, 0, 0);
		add_sample(0, 2560, 512);
		add_sample(-32768, 32767, -32768);
		add_random(100);
		wait_idle();

		// Opposite extremes: inverted outer gains, dead inner loop, zero clamps
		write_config(make_cfg(16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
			16'h0000, 16'h0000, 16'h0000));
		add_random(100);
		wait_idle();

		// Mid-range floor with ordinary gains
		write_config(make_cfg(16'd2048, 32'd262144, -32'sd200000, 32'd8192, -32'sd6000,
			16'd0, 16'hFFFF, 16'd20000));
		add_random(200);
		wait_idle();

		repeat (3) begin
			write_config(random_cfg());
			add_random(200);
			wait_idle();
		end

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/cpvc_pkg.sv
hw/rtl/cpvc_if.sv
hw/rtl/cpvc_regs.sv
hw/rtl/cpvc_ctrl.sv
hw/rtl/cpvc_dp.sv
hw/rtl/cascaded_pi_voltage_current_loop_unit.sv
bench/tb_top.sv
